>>> hw/rtl/ile_pkg.sv
// Shared types and constants for the indexed list engine.
// Request/result payload structs, operation and status codes, controller commands.
// No dependencies.
package ile_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int KIND_W  = 3;
    localparam int POS_W   = 9;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int FPOS_W  = 8;
    localparam int COUNT_W = 9;

    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIND   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] item_value;
    } ile_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] read_value;
        logic [FPOS_W-1:0]         found_position;
        logic [COUNT_W-1:0]        entry_count;
        logic signed [VALUE_W-1:0] head_value;
        logic signed [VALUE_W-1:0] tail_value;
    } ile_rsp_t;

    // where registered read data goes in the cycle after the read
    typedef enum logic [2:0] {
        DST_NONE,
        DST_DATA,
        DST_HEAD,
        DST_TAIL,
        DST_FIND,
        DST_UP,
        DST_DN
    } ile_dst_t;

    typedef enum logic [1:0] {
        RA_PTR,
        RA_POS,
        RA_ZERO,
        RA_LAST
    } ile_rsel_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_CNT_M1,
        PTR_POS_P1,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC
    } ile_ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } ile_cnt_op_t;

    typedef enum logic {
        WA_POS,
        WA_CNT
    } ile_wsel_t;

    typedef struct packed {
        logic              load_req;
        logic              set_status;
        logic [STAT_W-1:0] status;
        ile_ptr_op_t       ptr_op;
        ile_cnt_op_t       cnt_op;
        ile_rsel_t         rd_sel;
        ile_dst_t          rd_dst;
        logic              wr_en;
        ile_wsel_t         wr_sel;
        logic              out_load;
    } ile_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              pos_gt_cnt;
        logic              pos_ge_cnt;
        logic              pos_last;
        logic              full;
        logic              ptr_eq_pos;
        logic              ptr_last;
        logic              ptr_lt_cnt;
        logic              cmp_pending;
        logic              match;
        logic              out_busy;
    } ile_stat_t;

endpackage

>>> hw/rtl/ile_ctrl.sv
// Sequencer for the indexed list engine: decodes a request and walks it.
// Depends on ile_pkg (command and status structs, codes).
module ile_ctrl
    import ile_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ile_stat_t stat,
    output ile_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SHIFT_UP,
        ST_DRAIN_UP,
        ST_PUT,
        ST_SHIFT_DN,
        ST_DRAIN_DN,
        ST_FIND,
        ST_HEAD,
        ST_TAIL,
        ST_LAND,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.status     = STAT_OK;
        cmd.ptr_op     = PTR_HOLD;
        cmd.cnt_op     = CNT_HOLD;
        cmd.rd_sel     = RA_PTR;
        cmd.rd_dst     = DST_NONE;
        cmd.wr_sel     = WA_POS;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_HEAD;
                case (stat.kind)
                    KIND_APPEND: begin
                        if (stat.full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STAT_FULL;
                        end else begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WA_CNT;
                            cmd.cnt_op = CNT_INC;
                        end
                    end
                    KIND_INSERT: begin
                        if (stat.pos_gt_cnt) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STAT_RANGE;
                        end else if (stat.full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STAT_FULL;
                        end else if (!stat.pos_ge_cnt) begin
                            cmd.ptr_op = PTR_CNT_M1;
                            state_next = ST_SHIFT_UP;
                        end else begin
                            state_next = ST_PUT;
                        end
                    end
                    KIND_READ: begin
                        if (stat.pos_ge_cnt) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STAT_RANGE;
                        end else begin
                            cmd.rd_sel = RA_POS;
                            cmd.rd_dst = DST_DATA;
                        end
                    end
                    KIND_REMOVE: begin
                        if (stat.pos_ge_cnt) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STAT_RANGE;
                        end else if (stat.pos_last) begin
                            cmd.cnt_op = CNT_DEC;
                        end else begin
                            cmd.ptr_op = PTR_POS_P1;
                            state_next = ST_SHIFT_DN;
                        end
                    end
                    KIND_FIND: begin
                        cmd.ptr_op = PTR_ZERO;
                        state_next = ST_FIND;
                    end
                    KIND_CLEAR: begin
                        cmd.cnt_op = CNT_CLR;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SHIFT_UP: begin
                // read one entry, its copy one place up lands next cycle
                cmd.rd_sel = RA_PTR;
                cmd.rd_dst = DST_UP;
                if (stat.ptr_eq_pos) begin
                    state_next = ST_DRAIN_UP;
                end else begin
                    cmd.ptr_op = PTR_DEC;
                end
            end
            ST_DRAIN_UP: begin
                state_next = ST_PUT;
            end
            ST_PUT: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_POS;
                cmd.cnt_op = CNT_INC;
                state_next = ST_HEAD;
            end
            ST_SHIFT_DN: begin
                cmd.rd_sel = RA_PTR;
                cmd.rd_dst = DST_DN;
                if (stat.ptr_last) begin
                    state_next = ST_DRAIN_DN;
                end else begin
                    cmd.ptr_op = PTR_INC;
                end
            end
            ST_DRAIN_DN: begin
                cmd.cnt_op = CNT_DEC;
                state_next = ST_HEAD;
            end
            ST_FIND: begin
                if (stat.match) begin
                    state_next = ST_HEAD;
                end else if (stat.ptr_lt_cnt) begin
                    cmd.rd_sel = RA_PTR;
                    cmd.rd_dst = DST_FIND;
                    cmd.ptr_op = PTR_INC;
                end else if (!stat.cmp_pending) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_NOTFOUND;
                    state_next     = ST_HEAD;
                end
            end
            ST_HEAD: begin
                cmd.rd_sel = RA_ZERO;
                cmd.rd_dst = DST_HEAD;
                state_next = ST_TAIL;
            end
            ST_TAIL: begin
                cmd.rd_sel = RA_LAST;
                cmd.rd_dst = DST_TAIL;
                state_next = ST_LAND;
            end
            ST_LAND: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/ile_dpath.sv
// Datapath for the indexed list engine: entry memory, count, pointer, result register.
// Depends on ile_pkg (payload, command and status structs, codes).
module ile_dpath
    import ile_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  ile_req_t  s_data,
    input  ile_cmd_t  cmd,
    output ile_stat_t stat,
    output logic      m_valid,
    input  logic      m_ready,
    output ile_rsp_t  m_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int FP_W  = (IDX_W > FPOS_W) ? IDX_W : FPOS_W;
    localparam int EC_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic [VALUE_W-1:0] entry_mem [CAPACITY];

    logic [KIND_W-1:0]  kind_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [STAT_W-1:0]  status_reg;
    logic [VALUE_W-1:0] rdval_reg;
    logic [IDX_W-1:0]   found_reg;
    logic [VALUE_W-1:0] head_reg;
    logic [VALUE_W-1:0] tail_reg;
    logic [VALUE_W-1:0] rdata_reg;
    ile_dst_t           dst_reg;
    logic [IDX_W-1:0]   tag_addr_reg;
    logic               m_valid_reg;
    ile_rsp_t           m_data_reg;

    logic [CMP_W-1:0]   pos_ext, cnt_ext, pos_p1;
    logic [IDX_W-1:0]   pos_idx, last_idx, rd_addr, wr_addr;
    logic [CNT_W-1:0]   cnt_m1, ptr_p1, ptr_m1;
    logic [VALUE_W-1:0] wr_data;
    logic               move_land, wr_en, match;
    logic [FP_W-1:0]    found_ext;
    logic [EC_W-1:0]    count_ext;

    assign pos_ext  = CMP_W'(pos_reg);
    assign cnt_ext  = CMP_W'(cnt_reg);
    assign pos_p1   = pos_ext + 1'b1;
    assign pos_idx  = pos_ext[IDX_W-1:0];
    assign cnt_m1   = cnt_reg - 1'b1;
    assign last_idx = cnt_m1[IDX_W-1:0];
    assign ptr_p1   = ptr_reg + 1'b1;
    assign ptr_m1   = ptr_reg - 1'b1;

    assign move_land = (dst_reg == DST_UP) || (dst_reg == DST_DN);
    assign match     = (dst_reg == DST_FIND) && (rdata_reg == val_reg);

    always_comb begin
        stat             = '0;
        stat.kind        = kind_reg;
        stat.pos_gt_cnt  = pos_ext > cnt_ext;
        stat.pos_ge_cnt  = pos_ext >= cnt_ext;
        stat.pos_last    = pos_p1 == cnt_ext;
        stat.full        = cnt_reg == CNT_W'(CAPACITY);
        stat.ptr_eq_pos  = CMP_W'(ptr_reg) == pos_ext;
        stat.ptr_last    = ptr_p1 == cnt_reg;
        stat.ptr_lt_cnt  = ptr_reg < cnt_reg;
        stat.cmp_pending = dst_reg == DST_FIND;
        stat.match       = match;
        stat.out_busy    = m_valid_reg && !m_ready;
    end

    always_comb begin
        case (cmd.rd_sel)
            RA_PTR:  rd_addr = ptr_reg[IDX_W-1:0];
            RA_POS:  rd_addr = pos_idx;
            RA_ZERO: rd_addr = '0;
            RA_LAST: rd_addr = last_idx;
            default: rd_addr = '0;
        endcase
    end

    // a shifted copy lands in the cycle after its read and takes the port
    always_comb begin
        wr_en = move_land || cmd.wr_en;
        if (move_land) begin
            wr_addr = tag_addr_reg;
            wr_data = rdata_reg;
        end else begin
            wr_addr = (cmd.wr_sel == WA_CNT) ? cnt_reg[IDX_W-1:0] : pos_idx;
            wr_data = val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= entry_mem[rd_addr];
    end

    always_comb begin
        case (cmd.ptr_op)
            PTR_CNT_M1: ptr_next = cnt_m1;
            PTR_POS_P1: ptr_next = pos_p1[CNT_W-1:0];
            PTR_ZERO:   ptr_next = '0;
            PTR_INC:    ptr_next = ptr_p1;
            PTR_DEC:    ptr_next = ptr_m1;
            default:    ptr_next = ptr_reg;
        endcase
        case (cmd.cnt_op)
            CNT_INC: cnt_next = cnt_reg + 1'b1;
            CNT_DEC: cnt_next = cnt_m1;
            CNT_CLR: cnt_next = '0;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            dst_reg <= DST_NONE;
        end else begin
            cnt_reg <= cnt_next;
            dst_reg <= cmd.rd_dst;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        case (cmd.rd_dst)
            DST_UP:  tag_addr_reg <= ptr_p1[IDX_W-1:0];
            DST_DN:  tag_addr_reg <= ptr_m1[IDX_W-1:0];
            default: tag_addr_reg <= ptr_reg[IDX_W-1:0];
        endcase
        case (dst_reg)
            DST_DATA: rdval_reg <= rdata_reg;
            DST_HEAD: head_reg  <= rdata_reg;
            DST_TAIL: tail_reg  <= rdata_reg;
            DST_FIND: begin
                if (match) begin
                    found_reg <= tag_addr_reg;
                end
            end
            default: begin
            end
        endcase
        if (cmd.load_req) begin
            kind_reg   <= s_data.kind;
            pos_reg    <= s_data.position;
            val_reg    <= s_data.item_value;
            status_reg <= STAT_OK;
            rdval_reg  <= '0;
            found_reg  <= '0;
        end else if (cmd.set_status) begin
            status_reg <= cmd.status;
        end
    end

    assign found_ext = FP_W'(found_reg);
    assign count_ext = EC_W'(cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.status         <= status_reg;
            m_data_reg.read_value     <= rdval_reg;
            m_data_reg.found_position <= found_ext[FPOS_W-1:0];
            m_data_reg.entry_count    <= count_ext[COUNT_W-1:0];
            m_data_reg.head_value     <= (cnt_reg == '0) ? '0 : head_reg;
            m_data_reg.tail_value     <= (cnt_reg == '0) ? '0 : tail_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_port_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(move_land && cmd.wr_en))
        else $error("shifted copy and new value on the write port together");

    a_walk_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_sel == RA_PTR && cmd.rd_dst != DST_NONE) |-> ptr_reg < cnt_reg)
        else $error("walk pointer outside the list");

    a_found_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        match |=> CNT_W'(found_reg) < cnt_reg)
        else $error("found position outside the list");

endmodule

>>> hw/rtl/indexed_list_engine.sv
// Top level of the indexed list engine: ordered list of signed 32-bit values.
// Depends on ile_pkg, ile_ctrl and ile_dpath.
//
//  channel   | ports                      | moves
//  ----------+----------------------------+------------------------------------
//  request   | s_valid, s_ready, s_data   | kind, position, item_value
//  result    | m_valid, m_ready, m_data   | status, read_value, found_position,
//            |                            | entry_count, head_value, tail_value
//
// One request at a time through an entry memory with one write port and one
// registered read port. Insert below the length shifts the entries from the last down to
// p one place up, then writes the new value; remove below the last entry shifts the
// entries above p one place down; find compares entries from position 0 until a match or
// the end of the list. One entry is moved or compared per cycle, then the head and tail
// entries are read back.
// Reset: aresetn clears the length, so no memory sweep is needed.
// Stalls: a result held by m_ready low keeps its register; the next request is taken
// meanwhile and waits only at its own result.
module indexed_list_engine
    import ile_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ile_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ile_rsp_t m_data
);

    // command and status between sequencer and datapath
    ile_cmd_t  cmd;
    ile_stat_t stat;

    // decode, walk and sequence the memory accesses of one request
    ile_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // hold entries, length and the result register
    ile_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
